/* rtl/a2i_pkg.sv */
// ----------------------------------------------------------------------------
// a2i_pkg
// Types and constants shared by the string-to-integer parser modules.
// ----------------------------------------------------------------------------
package a2i_pkg;

   localparam int MAX_STRING_LEN = 255;
   localparam int IDX_W          = $clog2(MAX_STRING_LEN + 1);

   localparam logic [5:0] BASE_MAX    = 6'd36;
   localparam logic [5:0] BASE_DEC    = 6'd10;
   localparam logic [5:0] BASE_HEX    = 6'd16;
   localparam logic [5:0] BASE_OCT    = 6'd8;
   localparam logic [5:0] DIGIT_NONE  = 6'd63;

   localparam logic [31:0] UNSIGNED_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] SIGNED_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] SIGNED_MIN   = 32'h8000_0000;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  end_position;
      logic        range_error;
      logic        no_digits;
   } rsp_type;

   // One classified character as it waits between front and engine.
   typedef struct packed {
      logic             is_space;
      logic             is_minus;
      logic             is_plus;
      logic             is_zero;
      logic             is_x;
      logic [5:0]       digit;
      logic             last;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] nxt;
   } cls_type;

   // Parser state captured at the end of a string.
   typedef struct packed {
      logic [31:0]      acc;
      logic [IDX_W-1:0] stop;
      logic             neg;
      logic             ovf;
      logic             dseen;
   } fin_type;

endpackage

/* rtl/a2i_front.sv */
// ----------------------------------------------------------------------------
// a2i_front
// Accepts characters, classifies them, numbers them within the string and
// holds them in a two-entry queue for the parse engine.
// ----------------------------------------------------------------------------
module a2i_front import a2i_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   output cls_type q_data,
   input  logic    q_pop
);

   cls_type          q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             push;
   cls_type          cls;
   logic [7:0]       c;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = q_ff[rd_ptr_ff];

   always_comb begin
      c            = req_data.char_code;
      cls.is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
      cls.is_minus = (c == 8'h2D);
      cls.is_plus  = (c == 8'h2B);
      cls.is_zero  = (c == 8'h30);
      cls.is_x     = (c == 8'h78) || (c == 8'h58);
      if (c >= 8'h30 && c <= 8'h39) begin
         cls.digit = 6'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         cls.digit = 6'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         cls.digit = 6'(c - 8'h61 + 8'd10);
      end else begin
         cls.digit = DIGIT_NONE;
      end
      cls.last = req_data.last;
      cls.idx  = idx_ff;
      cls.nxt  = (idx_ff == IDX_W'(MAX_STRING_LEN)) ? idx_ff : idx_ff + 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
         idx_in    = req_data.last ? '0 : cls.nxt;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* rtl/a2i_engine.sv */
// ----------------------------------------------------------------------------
// a2i_engine
// Parse engine: walks the sign, prefix and digit phases one character per
// cycle unless a string end waits for the capture slot, accumulates digits
// with overflow detection and captures the final state of each string.
// ----------------------------------------------------------------------------
module a2i_engine import a2i_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [5:0] number_base,
   input  logic       q_valid,
   input  cls_type    q_data,
   output logic       q_pop,
   output logic       fin_valid,
   output fin_type    fin_data,
   input  logic       fin_take
);

   localparam logic [2:0] PH_SKIP       = 3'd0;
   localparam logic [2:0] PH_AFTER_SIGN = 3'd1;
   localparam logic [2:0] PH_ZERO_PEND  = 3'd2;
   localparam logic [2:0] PH_DIGITS     = 3'd3;
   localparam logic [2:0] PH_DONE       = 3'd4;

   logic [2:0]       ph_ff, ph_in;
   logic [5:0]       base_ff, base_in;
   logic             neg_ff, neg_in;
   logic             dseen_ff, dseen_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      acc_ff, acc_in;
   logic [IDX_W-1:0] stop_ff, stop_in;
   logic             fin_valid_ff, fin_valid_in;
   fin_type          fin_ff, fin_in;

   logic             start;
   logic             take;
   logic [5:0]       tbase;
   logic [37:0]      prod;
   logic [38:0]      sum;

   // A string end can only leave the engine once the capture slot is free.
   assign q_pop     = q_valid && (!q_data.last || !fin_valid_ff || fin_take);
   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_ff;

   always_comb begin
      ph_in        = ph_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      dseen_in     = dseen_ff;
      ovf_in       = ovf_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_take;
      start        = 1'b0;
      take         = 1'b0;
      tbase        = base_ff;
      prod         = '0;
      sum          = '0;

      if (q_pop) begin
         case (ph_ff)
            PH_SKIP: begin
               if (q_data.is_space) begin
                  ph_in = PH_SKIP;
               end else if (q_data.is_minus) begin
                  neg_in = 1'b1;
                  ph_in  = PH_AFTER_SIGN;
               end else if (q_data.is_plus) begin
                  ph_in = PH_AFTER_SIGN;
               end else begin
                  start = 1'b1;
               end
            end
            PH_AFTER_SIGN: begin
               start = 1'b1;
            end
            PH_ZERO_PEND: begin
               ph_in = PH_DIGITS;
               if (q_data.is_x) begin
                  if (base_ff == 6'd0) begin
                     base_in = BASE_HEX;
                  end
               end else begin
                  // The pending zero counts as a digit; the accumulator is still zero.
                  if (base_ff == 6'd0) begin
                     base_in = BASE_OCT;
                  end
                  dseen_in = 1'b1;
                  take     = 1'b1;
               end
            end
            PH_DIGITS: begin
               take = 1'b1;
            end
            default: begin
               ph_in = ph_ff;
            end
         endcase

         if (start) begin
            if (number_base == 6'd1 || number_base > BASE_MAX) begin
               ph_in = PH_DONE;
            end else if (q_data.is_zero &&
                         (number_base == 6'd0 || number_base == BASE_HEX)) begin
               base_in = number_base;
               ph_in   = PH_ZERO_PEND;
            end else begin
               base_in = (number_base == 6'd0) ? BASE_DEC : number_base;
               ph_in   = PH_DIGITS;
               take    = 1'b1;
            end
         end

         tbase = base_in;
         prod  = 38'(acc_ff) * 38'(tbase);
         sum   = 39'(prod) + 39'(q_data.digit);

         if (take) begin
            if (q_data.digit >= tbase) begin
               stop_in = q_data.idx;
               ph_in   = PH_DONE;
            end else begin
               dseen_in = 1'b1;
               if (!ovf_ff) begin
                  if (sum[38:32] != 7'd0) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = sum[31:0];
                  end
               end
            end
         end

         if (q_data.last) begin
            // The string ends as if a zero byte followed the last character.
            fin_in.acc   = acc_in;
            fin_in.neg   = neg_in;
            fin_in.ovf   = ovf_in;
            fin_in.dseen = dseen_in;
            fin_in.stop  = stop_in;
            if (ph_in == PH_ZERO_PEND) begin
               fin_in.dseen = 1'b1;
               fin_in.stop  = q_data.nxt;
            end else if (ph_in == PH_DIGITS) begin
               fin_in.stop = q_data.nxt;
            end
            fin_valid_in = 1'b1;
            ph_in        = PH_SKIP;
            base_in      = 6'd0;
            neg_in       = 1'b0;
            dseen_in     = 1'b0;
            ovf_in       = 1'b0;
            acc_in       = '0;
            stop_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_SKIP;
         base_ff      <= 6'd0;
         neg_ff       <= 1'b0;
         dseen_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         acc_ff       <= '0;
         stop_ff      <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         ph_ff        <= ph_in;
         base_ff      <= base_in;
         neg_ff       <= neg_in;
         dseen_ff     <= dseen_in;
         ovf_ff       <= ovf_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

endmodule

/* rtl/a2i_format.sv */
// ----------------------------------------------------------------------------
// a2i_format
// Turns a captured parse state into the result item: limit checks,
// saturation, negation, and the output register.
// ----------------------------------------------------------------------------
module a2i_format import a2i_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    signed_mode,
   input  logic    fin_valid,
   input  fin_type fin_data,
   output logic    fin_take,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type res;
   logic    over_signed;

   assign fin_take  = fin_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      over_signed     = fin_data.neg ? (fin_data.acc > SIGNED_MIN)
                                     : (fin_data.acc > SIGNED_MAX);
      res.value       = fin_data.acc;
      res.end_position = fin_data.stop[7:0];
      res.range_error = 1'b0;
      res.no_digits   = 1'b0;
      if (!fin_data.dseen) begin
         res.value        = '0;
         res.end_position = '0;
         res.no_digits    = 1'b1;
      end else if (fin_data.ovf && !signed_mode) begin
         res.value       = UNSIGNED_MAX;
         res.range_error = 1'b1;
      end else if (signed_mode && (fin_data.ovf || over_signed)) begin
         res.value       = fin_data.neg ? SIGNED_MIN : SIGNED_MAX;
         res.range_error = 1'b1;
      end else if (fin_data.neg) begin
         res.value = 32'd0 - fin_data.acc;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_data_ff <= res;
      end
   end

endmodule

/* rtl/ascii_to_integer_parser_core.sv */
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_core
// Streaming string-to-integer parser (32-bit, unsigned or signed): one
// character per item, one result item after the character marked last.
// ----------------------------------------------------------------------------
//   Port group   Direction  Carries
//   req_*        in         one character and its last flag per item
//   rsp_*        out        value, end position, range and no-digit flags
//   APB          in/out     number_base (0x0) and signed_mode (0x4)
//
// The block takes one character every cycle while req_stall is low. A result
// is registered in the queue, then in the engine's capture slot with the end
// state, then in the output register. The engine's multiply-accumulate
// (accumulator times base plus digit) sets the clock-to-clock path. Reset
// clears the control state; the queue, capture slot and output data are not
// reset. A stalled result holds the output register; the capture slot and
// the two-entry queue then fill before req_stall rises.
// ----------------------------------------------------------------------------
module ascii_to_integer_parser_core import a2i_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_NUMBER_BASE = 1'b0;
   localparam logic REG_SIGNED_MODE = 1'b1;

   logic [5:0] base_ff, base_in;
   logic       smode_ff, smode_in;
   logic       wr_en;
   logic       q_valid;
   cls_type    q_data;
   logic       q_pop;
   logic       fin_valid;
   fin_type    fin_data;
   logic       fin_take;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      base_in  = base_ff;
      smode_in = smode_ff;
      if (wr_en) begin
         if (paddr[2] == REG_NUMBER_BASE) begin
            base_in = pwdata[5:0];
         end else begin
            smode_in = pwdata[0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_SIGNED_MODE) begin
         prdata = {31'd0, smode_ff};
      end else begin
         prdata = {26'd0, base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 6'd0;
         smode_ff <= 1'b0;
      end else begin
         base_ff  <= base_in;
         smode_ff <= smode_in;
      end
   end

   a2i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   a2i_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .number_base (base_ff),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .fin_valid   (fin_valid),
      .fin_data    (fin_data),
      .fin_take    (fin_take)
   );

   a2i_format u_format (
      .clock       (clock),
      .reset       (reset),
      .signed_mode (smode_ff),
      .fin_valid   (fin_valid),
      .fin_data    (fin_data),
      .fin_take    (fin_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
